### sv/mrd_pkg.sv
// Shared types and constants for the multichannel median-of-3 range filter.
// No dependencies; every other file refers to it by scoped names.
package mrd_pkg;

    localparam int DIST_W       = 16;
    localparam int HIT_W        = 2;
    localparam int RING_LEN     = 3;
    localparam int CHANNELS_DEF = 4;

    localparam logic [DIST_W-1:0] FAULT_CODE = 16'd65535;
    localparam logic [DIST_W-1:0] HIST_RESET = 16'd8191;

    // configuration register reset values
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RST     = 16'd40;
    localparam logic [DIST_W-1:0] HIT_FAR_LIMIT_RST  = 16'd250;
    localparam logic [DIST_W-1:0] MAP_FAR_LIMIT_RST  = 16'd3500;
    localparam logic [HIT_W-1:0]  HIT_SATURATION_RST = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_FAR_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_FAR_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_SATURATION = 2'd3;

    typedef logic [RING_LEN-1:0][DIST_W-1:0] ring_t;

    typedef struct packed {
        logic [DIST_W-1:0] near_limit;
        logic [DIST_W-1:0] hit_far_limit;
        logic [DIST_W-1:0] map_far_limit;
        logic [HIT_W-1:0]  hit_saturation;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        channel;
        logic [DIST_W-1:0] filtered_distance;
        logic [HIT_W-1:0]  hit_count;
        logic              map_update;
        logic              sensor_fault;
    } result_t;

endpackage

### sv/multichannel_median3_range_debounce.sv
// Multichannel median-of-3 range filter with hit debounce and map flag.
//
// Input channel: sample and moving, qualified by in_valid; a beat is taken at a
// rising edge with in_valid high and in_stall low. Channels are served in
// fixed round-robin order from channel 0, one per accepted beat.
// Output channel: channel, filtered_distance, hit_count, map_update and
// sensor_fault, qualified by out_valid; the receiver holds a beat with
// out_stall. Exactly one result beat leaves for every input beat, in order.
// Path: an accepted beat is loaded into the input register, processed by
// mrd_filter and written to the output register once the output register is
// free or being emptied; out_stall can hold it in the input register.
// Throughput: one beat per cycle while out_stall is low, set by the per-step
// read-modify-write of the per-channel ring, write index and hit counter.
// A stalled output beat holds; the input register still takes one more beat,
// and in_stall rises only when both the input and output registers are full.
// Configuration: cfg_write, cfg_index and cfg_data write one limit register
// per cycle, to be used only while no beat is in flight.
// Reset (rst_n low, asynchronous) empties both registers, loads the register
// reset values, fills every ring with 8191 and returns to channel 0.
// Depends on mrd_pkg, mrd_cfg_regs and mrd_filter.
module multichannel_median3_range_debounce #(
    parameter int CHANNELS = mrd_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mrd_pkg::DIST_W-1:0]          sample,
    input  logic                                moving,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          channel,
    output logic [mrd_pkg::DIST_W-1:0]          filtered_distance,
    output logic [mrd_pkg::HIT_W-1:0]           hit_count,
    output logic                                map_update,
    output logic                                sensor_fault,
    input  logic                                cfg_write,
    input  logic [mrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mrd_pkg::DIST_W-1:0]          cfg_data
);

    mrd_pkg::cfg_t              cfg;
    mrd_pkg::result_t           result;
    mrd_pkg::result_t           out_reg;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [mrd_pkg::DIST_W-1:0] s1_sample_reg;
    logic                       s1_moving_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       advance;
    logic                       in_accept;
    logic                       step;

    // the pipeline moves whenever the output register is free or being emptied
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign step      = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = s1_valid_reg;
        end
        if (in_accept)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= sample;
            s1_moving_reg <= moving;
        end
        if (step)
            out_reg <= result;
    end

    mrd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mrd_filter #(
        .CHANNELS (CHANNELS)
    ) u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (s1_sample_reg),
        .moving (s1_moving_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign out_valid         = out_valid_reg;
    assign channel           = out_reg.channel;
    assign filtered_distance = out_reg.filtered_distance;
    assign hit_count         = out_reg.hit_count;
    assign map_update        = out_reg.map_update;
    assign sensor_fault      = out_reg.sensor_fault;

endmodule

### sv/mrd_cfg_regs.sv
// Configuration register file: near, hit and map limits and hit saturation.
// Depends on mrd_pkg for register indexes, reset values and cfg_t.
module mrd_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [mrd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mrd_pkg::DIST_W-1:0]            cfg_data,
    output mrd_pkg::cfg_t                         cfg
);

    mrd_pkg::cfg_t cfg_reg;
    mrd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                mrd_pkg::REG_NEAR_LIMIT:     cfg_next.near_limit     = cfg_data;
                mrd_pkg::REG_HIT_FAR_LIMIT:  cfg_next.hit_far_limit  = cfg_data;
                mrd_pkg::REG_MAP_FAR_LIMIT:  cfg_next.map_far_limit  = cfg_data;
                mrd_pkg::REG_HIT_SATURATION:
                    cfg_next.hit_saturation = cfg_data[mrd_pkg::HIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit     <= mrd_pkg::NEAR_LIMIT_RST;
            cfg_reg.hit_far_limit  <= mrd_pkg::HIT_FAR_LIMIT_RST;
            cfg_reg.map_far_limit  <= mrd_pkg::MAP_FAR_LIMIT_RST;
            cfg_reg.hit_saturation <= mrd_pkg::HIT_SATURATION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/mrd_filter.sv
// Per-channel state (sample rings, write indexes, hit counters, channel pointer)
// and the single-pass median, debounce and window logic. Depends on mrd_pkg.
module mrd_filter #(
    parameter int CHANNELS = mrd_pkg::CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [mrd_pkg::DIST_W-1:0]  sample,
    input  logic                        moving,
    input  mrd_pkg::cfg_t               cfg,
    output mrd_pkg::result_t            result
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    mrd_pkg::ring_t             hist_reg  [CHANNELS];
    logic [1:0]                 pos_reg   [CHANNELS];
    logic [mrd_pkg::HIT_W-1:0]  hit_reg   [CHANNELS];
    logic [CH_W-1:0]            ptr_reg;

    mrd_pkg::ring_t             row_next;
    logic [1:0]                 pos_next;
    logic [mrd_pkg::HIT_W-1:0]  hit_next;
    logic [CH_W-1:0]            ptr_next;

    mrd_pkg::ring_t             row;
    logic [1:0]                 pos;
    logic [1:0]                 prev;
    logic                       fault;
    logic [mrd_pkg::DIST_W-1:0] val;
    logic [mrd_pkg::DIST_W-1:0] a;
    logic [mrd_pkg::DIST_W-1:0] b;
    logic [mrd_pkg::DIST_W-1:0] c;
    logic [mrd_pkg::DIST_W-1:0] lo_ab;
    logic [mrd_pkg::DIST_W-1:0] hi_ab;
    logic [mrd_pkg::DIST_W-1:0] lo_hc;
    logic [mrd_pkg::DIST_W-1:0] med;
    logic                       above_near;
    logic                       in_hit;
    logic [CH_W+1:0]            ch_ext;

    always_comb
    begin
        row   = hist_reg[ptr_reg];
        // an out-of-range write index restarts the ring
        pos   = (pos_reg[ptr_reg] == 2'd3) ? 2'd0 : pos_reg[ptr_reg];
        prev  = (pos == 2'd0) ? 2'd2 : pos - 2'd1;
        fault = (sample == mrd_pkg::FAULT_CODE);
        // on a timeout, repeat the newest stored sample
        val   = fault ? row[prev] : sample;

        row_next      = row;
        row_next[pos] = val;
        pos_next      = (pos == 2'd2) ? 2'd0 : pos + 2'd1;

        a     = row_next[0];
        b     = row_next[1];
        c     = row_next[2];
        lo_ab = (a < b) ? a : b;
        hi_ab = (a > b) ? a : b;
        lo_hc = (hi_ab < c) ? hi_ab : c;
        med   = (lo_ab > lo_hc) ? lo_ab : lo_hc;

        above_near = (med > cfg.near_limit);
        in_hit     = above_near && (med <= cfg.hit_far_limit);

        priority if (!in_hit)
            hit_next = '0;
        else if (hit_reg[ptr_reg] < cfg.hit_saturation)
            hit_next = hit_reg[ptr_reg] + mrd_pkg::HIT_W'(1);
        else
            hit_next = hit_reg[ptr_reg];

        ptr_next = (ptr_reg == LAST_CH) ? '0 : ptr_reg + CH_W'(1);
        ch_ext   = {2'b00, ptr_reg};

        result.channel           = ch_ext[1:0];
        result.filtered_distance = med;
        result.hit_count         = hit_next;
        result.map_update        = moving && above_near && (med < cfg.map_far_limit);
        result.sensor_fault      = fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                hist_reg[i] <= {mrd_pkg::RING_LEN{mrd_pkg::HIST_RESET}};
                pos_reg[i]  <= '0;
                hit_reg[i]  <= '0;
            end
            ptr_reg <= '0;
        end
        else if (step)
        begin
            hist_reg[ptr_reg] <= row_next;
            pos_reg[ptr_reg]  <= pos_next;
            hit_reg[ptr_reg]  <= hit_next;
            ptr_reg           <= ptr_next;
        end
    end

endmodule

### sv/mrd_checker.sv
// Port-level checker for the range filter, bound to the top level below.
// Depends on mrd_pkg and the top level's port list.
module mrd_checker #(
    parameter int CHANNELS = mrd_pkg::CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_stall,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [1:0]                 channel,
    input  logic [mrd_pkg::DIST_W-1:0] filtered_distance
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    logic [CH_W-1:0] exp_ch_reg;
    logic [CH_W-1:0] exp_ch_next;
    logic [CH_W+1:0] exp_ext;

    // track which channel the next result beat must carry
    always_comb
    begin
        exp_ch_next = exp_ch_reg;
        if (out_valid && !out_stall)
            exp_ch_next = (exp_ch_reg == LAST_CH) ? '0 : exp_ch_reg + CH_W'(1);
        exp_ext = {2'b00, exp_ch_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_ch_reg <= '0;
        else
            exp_ch_reg <= exp_ch_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(filtered_distance) && $stable(channel))
        else $error("stalled result beat changed");

    a_round_robin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> channel == exp_ext[1:0])
        else $error("result beat out of round-robin order");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

endmodule

bind multichannel_median3_range_debounce mrd_checker #(
    .CHANNELS (CHANNELS)
) u_mrd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .channel           (channel),
    .filtered_distance (filtered_distance)
);
